// ----- src/first_fit_heap_allocator_unit_macros.svh -----
// Assertion macros shared by the allocator RTL.
// No dependencies; expects signals named clock and reset in the using module.
`ifndef FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH
`define FIRST_FIT_HEAP_ALLOCATOR_UNIT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define FFHA_ASSERT(name, prop, msg) \
   name: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// Condition that must never be seen outside reset.
`define FFHA_NEVER(name, cond, msg) \
   name: assert property (@(posedge clock) disable iff (reset) !(cond)) else $error(msg);

`endif

// ----- src/ffha_pkg.sv -----
// Package for the first-fit heap allocator: sizes, codes and payload types.
// No dependencies.
package ffha_pkg;

   localparam int MAX_BLOCKS   = 64;
   localparam int HEADER_BYTES = 24;
   localparam int ADDR_BITS    = 24;
   localparam int SIZE_BITS    = 24;
   localparam int IDX_BITS     = $clog2(MAX_BLOCKS);
   localparam int CNT_BITS     = $clog2(MAX_BLOCKS + 1);
   localparam int SUM_BITS     = ((ADDR_BITS > SIZE_BITS) ? ADDR_BITS : SIZE_BITS) + 2;

   localparam logic [1:0] CMD_ALLOC   = 2'd0;
   localparam logic [1:0] CMD_FREE    = 2'd1;
   localparam logic [1:0] CMD_REALLOC = 2'd2;
   localparam logic [1:0] CMD_NONE    = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_LIMIT   = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_UNKNOWN = 2'd3;

   typedef struct packed {
      logic [1:0]           cmd;
      logic [ADDR_BITS-1:0] block_address;
      logic [SIZE_BITS-1:0] request_size;
   } req_payload_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] result_address;
      logic [1:0]           status;
   } rsp_payload_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] addr;
      logic [SIZE_BITS-1:0] size;
      logic                 is_free;
   } entry_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_FIND,
      S_FIT,
      S_PAYLOAD,
      S_APPEND,
      S_RELEASE,
      S_DONE
   } state_type;

endpackage

// ----- src/first_fit_heap_allocator_unit.sv -----
// First-fit heap allocator: block table in one memory, scanned by a small sequencer.
// Depends on ffha_pkg and first_fit_heap_allocator_unit_macros.svh.
//
//   channel   direction  handshake                     beat contents
//   req_      in         req_valid / req_ready         req_payload_type (cmd, address, size)
//   rsp_      out        rsp_valid / rsp_ready         rsp_payload_type (address, status)
//   csr_      in         csr_write_enable, no wait     heap_limit
//
// Each table scan reads one entry a cycle through the single memory read port.
// Reset (synchronous, active high) empties the table and clears the break at once;
//   no clearing pass, entries beyond the count are never read.
// req_ready is high in idle only. A finished result sits in the rsp_ register, so
//   the next request beat is taken while that result waits; a later result stalls
//   in the done step until the rsp_ register frees.
module first_fit_heap_allocator_unit
   import ffha_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  req_payload_type      req_payload,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rsp_payload_type      rsp_payload,
   input  logic                 csr_write_enable,
   input  logic [ADDR_BITS-1:0] csr_write_data
);

`include "first_fit_heap_allocator_unit_macros.svh"

   // block table, one write and one registered read per cycle
   entry_type            table_mem [MAX_BLOCKS];
   entry_type            rd_data_ff;
   logic                 mem_we;
   logic [IDX_BITS-1:0]  mem_waddr;
   entry_type            mem_wdata;

   state_type            state_ff, state_in;
   req_payload_type      req_ff, req_in;
   logic [ADDR_BITS-1:0] limit_ff;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic [ADDR_BITS-1:0] break_ff, break_in;

   // scan pipeline: scan_ff issues reads, chk_* tags the entry now in rd_data_ff
   logic [CNT_BITS-1:0]  scan_ff, scan_in;
   logic                 chk_vld_ff, chk_vld_in;
   logic [IDX_BITS-1:0]  chk_idx_ff, chk_idx_in;

   // block being released (free, or old block of a growing realloc)
   logic [IDX_BITS-1:0]  old_idx_ff, old_idx_in;
   logic [ADDR_BITS-1:0] old_addr_ff, old_addr_in;
   logic [SIZE_BITS-1:0] old_size_ff, old_size_in;
   logic                 realloc_ff, realloc_in;

   logic [SUM_BITS-1:0]  pay_ff, pay_in;
   logic [SUM_BITS-1:0]  new_break;
   logic [ADDR_BITS-1:0] res_ff, res_in;
   logic [1:0]           st_ff, st_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   rsp_payload_type      rsp_data_ff, rsp_data_in;

   logic                 issue;
   logic                 find_hit, fit_hit, scan_miss, old_is_last;

   assign req_ready   = (state_ff == S_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   assign issue     = (scan_ff < count_ff);
   assign find_hit  = chk_vld_ff && (rd_data_ff.addr == req_ff.block_address);
   assign fit_hit   = chk_vld_ff && rd_data_ff.is_free
                      && (rd_data_ff.size >= req_ff.request_size);
   assign scan_miss = !chk_vld_ff && !issue;
   assign new_break = pay_ff + SUM_BITS'(req_ff.request_size);
   assign old_is_last = ((CNT_BITS'(old_idx_ff) + CNT_BITS'(1)) == count_ff);

   always_comb begin
      state_in     = state_ff;
      req_in       = req_ff;
      count_in     = count_ff;
      break_in     = break_ff;
      scan_in      = scan_ff;
      chk_vld_in   = 1'b0;
      chk_idx_in   = scan_ff[IDX_BITS-1:0];
      old_idx_in   = old_idx_ff;
      old_addr_in  = old_addr_ff;
      old_size_in  = old_size_ff;
      realloc_in   = realloc_ff;
      pay_in       = pay_ff;
      res_in       = res_ff;
      st_in        = st_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      mem_we       = 1'b0;
      mem_waddr    = chk_idx_ff;
      mem_wdata    = rd_data_ff;

      // read issue is shared by both scan states
      if ((state_ff == S_FIND || state_ff == S_FIT) && issue) begin
         chk_vld_in = 1'b1;
         scan_in    = scan_ff + CNT_BITS'(1);
      end

      unique case (state_ff)
         S_IDLE: begin
            scan_in    = '0;
            realloc_in = 1'b0;
            res_in     = '0;
            st_in      = ST_OK;
            if (req_valid) begin
               req_in = req_payload;
               case (req_payload.cmd)
                  CMD_ALLOC: state_in = S_FIT;
                  CMD_FREE: begin
                     state_in = (req_payload.block_address == '0) ? S_DONE : S_FIND;
                  end
                  CMD_REALLOC: begin
                     if (req_payload.block_address == '0 || req_payload.request_size == '0)
                        state_in = S_FIT;
                     else
                        state_in = S_FIND;
                  end
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_FIND: begin
            if (find_hit) begin
               old_idx_in  = chk_idx_ff;
               old_addr_in = rd_data_ff.addr;
               old_size_in = rd_data_ff.size;
               if (req_ff.cmd == CMD_FREE) begin
                  state_in = S_RELEASE;
               end else if (rd_data_ff.size >= req_ff.request_size) begin
                  res_in   = req_ff.block_address;
                  state_in = S_DONE;
               end else begin
                  realloc_in = 1'b1;
                  scan_in    = '0;
                  chk_vld_in = 1'b0;
                  state_in   = S_FIT;
               end
            end else if (scan_miss) begin
               st_in    = ST_UNKNOWN;
               state_in = S_DONE;
            end
         end
         S_FIT: begin
            if (fit_hit) begin
               mem_we            = 1'b1;
               mem_waddr         = chk_idx_ff;
               mem_wdata         = rd_data_ff;
               mem_wdata.is_free = 1'b0;
               res_in            = rd_data_ff.addr;
               state_in          = realloc_ff ? S_RELEASE : S_DONE;
            end else if (scan_miss) begin
               state_in = S_PAYLOAD;
            end
         end
         S_PAYLOAD: begin
            pay_in = SUM_BITS'(break_ff) + SUM_BITS'(HEADER_BYTES);
            if (count_ff == CNT_BITS'(MAX_BLOCKS)) begin
               st_in    = ST_FULL;
               state_in = S_DONE;
            end else begin
               state_in = S_APPEND;
            end
         end
         S_APPEND: begin
            if (new_break > SUM_BITS'(limit_ff)) begin
               st_in    = ST_LIMIT;
               state_in = S_DONE;
            end else begin
               mem_we            = 1'b1;
               mem_waddr         = count_ff[IDX_BITS-1:0];
               mem_wdata.addr    = pay_ff[ADDR_BITS-1:0];
               mem_wdata.size    = req_ff.request_size;
               mem_wdata.is_free = 1'b0;
               count_in          = count_ff + CNT_BITS'(1);
               break_in          = new_break[ADDR_BITS-1:0];
               res_in            = pay_ff[ADDR_BITS-1:0];
               state_in          = realloc_ff ? S_RELEASE : S_DONE;
            end
         end
         S_RELEASE: begin
            // the break always ends the last block, so dropping it lands on its header
            if (old_is_last) begin
               break_in = old_addr_ff - ADDR_BITS'(HEADER_BYTES);
               count_in = count_ff - CNT_BITS'(1);
            end else begin
               mem_we            = 1'b1;
               mem_waddr         = old_idx_ff;
               mem_wdata.addr    = old_addr_ff;
               mem_wdata.size    = old_size_ff;
               mem_wdata.is_free = 1'b1;
            end
            state_in = S_DONE;
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in               = 1'b1;
               rsp_data_in.result_address = res_ff;
               rsp_data_in.status         = st_ff;
               state_in                   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         break_ff     <= '0;
         limit_ff     <= '1;
         chk_vld_ff   <= 1'b0;
         realloc_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         break_ff     <= break_in;
         chk_vld_ff   <= chk_vld_in;
         realloc_ff   <= realloc_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable)
            limit_ff <= csr_write_data;
      end
   end

   always_ff @(posedge clock) begin
      req_ff      <= req_in;
      scan_ff     <= scan_in;
      chk_idx_ff  <= chk_idx_in;
      old_idx_ff  <= old_idx_in;
      old_addr_ff <= old_addr_in;
      old_size_ff <= old_size_in;
      pay_ff      <= pay_in;
      res_ff      <= res_in;
      st_ff       <= st_in;
      rsp_data_ff <= rsp_data_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we)
         table_mem[mem_waddr] <= mem_wdata;
      rd_data_ff <= table_mem[scan_ff[IDX_BITS-1:0]];
   end

   `FFHA_NEVER(a_count_range, count_ff > CNT_BITS'(MAX_BLOCKS), "entry count above table size")
   `FFHA_ASSERT(a_empty_break, (count_ff == '0) |-> (break_ff == '0), "break set on empty table")
   `FFHA_ASSERT(a_rsp_from_done, $rose(rsp_valid_ff) |-> $past(state_ff == S_DONE), "result not from done step")
   `FFHA_ASSERT(a_append_count, (state_ff == S_APPEND && mem_we) |=> (count_ff == $past(count_ff) + CNT_BITS'(1)), "append did not grow table")
   `FFHA_NEVER(a_write_range, mem_we && state_ff != S_APPEND && CNT_BITS'(mem_waddr) >= count_ff, "write outside table")

endmodule

// ----- sim/tb_first_fit_heap_allocator_unit.sv -----
// Self-checking bench for first_fit_heap_allocator_unit: alloc, free and realloc beats
// are checked against an in-bench model of the block table and the program break.
// Depends on ffha_pkg and the allocator RTL only.
`timescale 1ns / 1ps

module tb_first_fit_heap_allocator_unit;
   import ffha_pkg::*;

   localparam int CYCLE_LIMIT = 3_000_000;
   // Longest request: a growing realloc, which scans the table twice.
   localparam int SETTLE_CYCLES = 2 * MAX_BLOCKS + 40;
   localparam int HOLD_CYCLES = 600;

   // DUT inputs, all known from time zero.
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   req_payload_type      req_payload = '0;
   logic                 rsp_ready = 1'b0;
   logic                 csr_write_enable = 1'b0;
   logic [ADDR_BITS-1:0] csr_write_data = '0;
   logic                 req_ready;
   logic                 rsp_valid;
   rsp_payload_type      rsp_payload;

   // Beats waiting to go out, and the replies they must produce, in order.
   req_payload_type queued_ops[$];
   rsp_payload_type due_replies[$];
   int accepted_beats = 0;
   int checked_beats = 0;
   int fails = 0;
   int cycle_count = 0;

   // Idle percentages per side; set between phases.
   int send_gap_pct = 0;
   int recv_stall_pct = 0;

   // Long receiver hold-off so the result register fills and req_ready drops.
   logic hold_go = 1'b0;
   logic hold_done = 1'b0;
   int   hold_left = 0;

   // Bench copy of the heap: block table, count, break and limit.
   logic [ADDR_BITS-1:0] blk_addr [MAX_BLOCKS];
   logic [SIZE_BITS-1:0] blk_size [MAX_BLOCKS];
   logic                 blk_free [MAX_BLOCKS];
   int                   blk_count = 0;
   logic [ADDR_BITS-1:0] brk = '0;
   logic [ADDR_BITS-1:0] limit_reg = {ADDR_BITS{1'b1}};

   rsp_payload_type want;

   first_fit_heap_allocator_unit u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------
   // Heap model
   // ---------------------------------------------------------------------

   // Index of the block whose payload starts at addr, or -1.
   function automatic int find_block(input logic [ADDR_BITS-1:0] addr);
      int i;
      int hit;
      hit = -1;
      for (i = 0; i < blk_count && hit < 0; i++)
         if (blk_addr[i] == addr) hit = i;
      return hit;
   endfunction

   // First fit over free blocks, else append at the break.
   // Table full is tested before the limit; a failed append leaves all state alone.
   function automatic logic [1:0] take_block(input logic [SIZE_BITS-1:0] size,
                                             output logic [ADDR_BITS-1:0] addr);
      int i;
      int hit;
      logic [SUM_BITS-1:0] base;
      logic [SUM_BITS-1:0] top;
      addr = '0;
      hit = -1;
      for (i = 0; i < blk_count && hit < 0; i++)
         if (blk_free[i] && blk_size[i] >= size) hit = i;
      if (hit >= 0) begin
         blk_free[hit] = 1'b0;
         addr = blk_addr[hit];
         return ST_OK;
      end
      if (blk_count >= MAX_BLOCKS) return ST_FULL;
      base = SUM_BITS'(brk) + SUM_BITS'(HEADER_BYTES);
      top  = base + SUM_BITS'(size);
      if (top > SUM_BITS'(limit_reg)) return ST_LIMIT;
      blk_addr[blk_count] = base[ADDR_BITS-1:0];
      blk_size[blk_count] = size;
      blk_free[blk_count] = 1'b0;
      blk_count++;
      brk  = top[ADDR_BITS-1:0];
      addr = base[ADDR_BITS-1:0];
      return ST_OK;
   endfunction

   // Last block is dropped and the break pulled back; any other is just marked free.
   function automatic void give_back(input int idx);
      if (idx + 1 == blk_count) begin
         brk = brk - ADDR_BITS'(HEADER_BYTES) - blk_size[idx];
         blk_count--;
      end else begin
         blk_free[idx] = 1'b1;
      end
   endfunction

   // Advances the model by one request beat and returns the reply it owes.
   function automatic rsp_payload_type apply_heap_op(input req_payload_type op);
      rsp_payload_type r;
      int idx;
      r = '0;
      r.status = ST_OK;
      case (op.cmd)
         CMD_ALLOC: begin
            r.status = take_block(op.request_size, r.result_address);
         end
         CMD_FREE: begin
            if (op.block_address != '0) begin
               idx = find_block(op.block_address);
               if (idx < 0) r.status = ST_UNKNOWN;
               else give_back(idx);
            end
         end
         CMD_REALLOC: begin
            if (op.block_address == '0 || op.request_size == '0) begin
               r.status = take_block(op.request_size, r.result_address);
            end else begin
               idx = find_block(op.block_address);
               if (idx < 0) begin
                  r.status = ST_UNKNOWN;
               end else if (blk_size[idx] >= op.request_size) begin
                  r.result_address = op.block_address;
               end else begin
                  // new block first; the old one only goes if that worked
                  r.status = take_block(op.request_size, r.result_address);
                  if (r.status == ST_OK) give_back(idx);
               end
            end
         end
         default: ;
      endcase
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------

   task automatic issue(input logic [1:0] cmd, input logic [ADDR_BITS-1:0] addr,
                        input logic [SIZE_BITS-1:0] size);
      req_payload_type op;
      op.cmd = cmd;
      op.block_address = addr;
      op.request_size = size;
      due_replies.push_back(apply_heap_op(op));
      queued_ops.push_back(op);
   endtask

   // Mostly live payload addresses (used or free), some near misses, null and noise.
   function automatic logic [ADDR_BITS-1:0] pick_address();
      int r;
      r = $urandom_range(99);
      if (r < 5) return '0;
      if (r < 13 || blk_count == 0) return ADDR_BITS'($urandom);
      if (r < 18) return blk_addr[$urandom_range(blk_count - 1)] + ADDR_BITS'(1);
      return blk_addr[$urandom_range(blk_count - 1)];
   endfunction

   // Small sizes keep the table busy; a rare full-width size pushes the break far out.
   function automatic logic [SIZE_BITS-1:0] pick_size();
      int r;
      r = $urandom_range(99);
      if (r < 2) return SIZE_BITS'($urandom);
      if (r < 12) return SIZE_BITS'($urandom_range(15));
      if (r < 20) return SIZE_BITS'($urandom_range(4095));
      return SIZE_BITS'($urandom_range(300));
   endfunction

   task automatic random_item(input int alloc_pct);
      int r;
      logic [1:0] cmd;
      r = $urandom_range(99);
      if (r < alloc_pct) cmd = CMD_ALLOC;
      else if (r >= 97) cmd = CMD_NONE;
      else if (r < alloc_pct + (97 - alloc_pct) / 2) cmd = CMD_FREE;
      else cmd = CMD_REALLOC;
      issue(cmd, pick_address(), pick_size());
   endtask

   // Idle once every queued beat has gone out and every reply has come back.
   task automatic wait_drained();
      while (queued_ops.size() != 0 || req_valid || checked_beats != accepted_beats)
         @(negedge clock);
   endtask

   task automatic write_limit(input logic [ADDR_BITS-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      limit_reg = value;
      @(negedge clock);
   endtask

   task automatic run_phase(input logic [ADDR_BITS-1:0] lim, input int gap, input int stall,
                            input int n, input int alloc_pct);
      wait_drained();
      write_limit(lim);
      send_gap_pct = gap;
      recv_stall_pct = stall;
      repeat (n) random_item(alloc_pct);
   endtask

   // ---------------------------------------------------------------------
   // Driver: one request beat at a time off queued_ops; valid held until taken.
   // ---------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) accepted_beats <= accepted_beats + 1;
         if (queued_ops.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
            req_payload <= queued_ops.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Receiver: random stalls, plus one long hold-off counted here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_done <= 1'b0;
         hold_left <= 0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES;
         rsp_ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Monitor: a reply counts only against a request beat taken at an earlier edge.
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (checked_beats == accepted_beats) begin
            $error("reply beat with no request outstanding: address %h status %0d",
                   rsp_payload.result_address, rsp_payload.status);
            fails++;
         end else begin
            want = due_replies.pop_front();
            checked_beats <= checked_beats + 1;
            if (rsp_payload.result_address !== want.result_address) begin
               $error("result_address: expected %h, got %h",
                      want.result_address, rsp_payload.result_address);
               fails++;
            end
            if (rsp_payload.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_payload.status);
               fails++;
            end
         end
      end
   end

   // Watchdog.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("[first_fit_heap_allocator_unit] ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------
   // Sequence of phases
   // ---------------------------------------------------------------------
   initial begin
      logic [ADDR_BITS-1:0] last_addr;
      longint lim;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Sender gaps light, receiver stalls heavy.
      write_limit({ADDR_BITS{1'b1}});
      send_gap_pct = 31;
      recv_stall_pct = 88;

      // Directed: field extremes, every command and the corner cases.
      issue(CMD_NONE, {ADDR_BITS{1'b1}}, {SIZE_BITS{1'b1}});
      issue(CMD_ALLOC, '0, '0);                              // zero-size block
      issue(CMD_ALLOC, 24'hABCDEF, {SIZE_BITS{1'b1}});        // past the limit
      issue(CMD_ALLOC, '0, 24'd100);
      issue(CMD_ALLOC, '0, 24'd50);
      issue(CMD_FREE, '0, {SIZE_BITS{1'b1}});                // free of null
      issue(CMD_FREE, {ADDR_BITS{1'b1}}, '0);                // unknown address
      issue(CMD_REALLOC, 24'd1, 24'd5);                      // unknown address
      issue(CMD_FREE, blk_addr[1], '0);                      // middle block
      issue(CMD_FREE, blk_addr[1], '0);                      // already free
      issue(CMD_ALLOC, '0, 24'd80);                          // first fit reuse
      issue(CMD_REALLOC, blk_addr[2], 24'd10);               // fits, kept
      issue(CMD_REALLOC, blk_addr[2], 24'd500);              // grows: move, old freed
      issue(CMD_REALLOC, '0, 24'd30);                        // null acts as alloc
      issue(CMD_REALLOC, blk_addr[3], '0);                   // zero size acts as alloc
      last_addr = blk_addr[blk_count - 1];
      issue(CMD_FREE, last_addr, '0);                        // last block: break drops
      issue(CMD_FREE, last_addr, '0);                        // now gone
      issue(CMD_REALLOC, blk_addr[3], {SIZE_BITS{1'b1}});    // failed move keeps old
      issue(CMD_FREE, blk_addr[0], '0);
      issue(CMD_ALLOC, '0, '0);
      issue(CMD_REALLOC, blk_addr[1], blk_size[1]);          // exact size, kept
      issue(CMD_FREE, 24'h800000, 24'h800000);
      issue(CMD_NONE, '0, '0);

      run_phase({ADDR_BITS{1'b1}}, 31, 88, 400, 60);
      run_phase('0, 31, 88, 100, 50);                        // every append hits the limit

      // Roles swapped: sender sparse, receiver mostly ready.
      wait_drained();
      lim = longint'(brk) + 600;
      if (lim > longint'({ADDR_BITS{1'b1}})) lim = longint'({ADDR_BITS{1'b1}});
      run_phase(ADDR_BITS'(lim), 88, 31, 350, 55);
      run_phase({ADDR_BITS{1'b1}}, 88, 31, 300, 85);         // alloc-heavy: table fills

      // No idling on either side, then one long receiver hold-off.
      run_phase(ADDR_BITS'($urandom_range(20000, 2000)), 0, 0, 300, 50);
      hold_go = 1'b1;

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (due_replies.size() != 0) begin
         $error("%0d expected replies never arrived", due_replies.size());
      end
      if (fails == 0 && due_replies.size() == 0) begin
         $display("[first_fit_heap_allocator_unit] OK");
      end else begin
         $display("[first_fit_heap_allocator_unit] ERROR");
      end
      $finish;
   end

endmodule
